FILE: rtl/core/ubs_pkg.sv
// ----------------------------------------------------------------------------
// ubs_pkg
// shared constants, op codes and status types of the uart bit serializer
// ----------------------------------------------------------------------------
package ubs_pkg;

	localparam int DATA_BITS = 8;
	localparam int FRAME_LEN = DATA_BITS + 2;
	localparam int TX_IDX_W  = $clog2(FRAME_LEN + 1);
	localparam int RX_IDX_W  = $clog2(DATA_BITS + 1);
	localparam int BYTE_W    = 8;
	localparam int OP_W      = 3;
	localparam int IN_DATA_W = 16;
	localparam int OUT_DATA_W = 16;

	localparam logic [OP_W-1:0] OP_TX_TICK = 3'd0;
	localparam logic [OP_W-1:0] OP_RX_TICK = 3'd1;
	localparam logic [OP_W-1:0] OP_RX_EDGE = 3'd2;
	localparam logic [OP_W-1:0] OP_SEND    = 3'd3;
	localparam logic [OP_W-1:0] OP_READ    = 3'd4;

	localparam logic CFG_TX_EVENT = 1'b0;
	localparam logic CFG_RX_EVENT = 1'b1;

	typedef struct packed {
		logic              step;
		logic [OP_W-1:0]   op;
		logic [BYTE_W-1:0] tx_byte;
		logic              rx_level;
	} cmd_t;

	typedef struct packed {
		logic line;
		logic done;
		logic event_flag;
	} tx_stat_t;

	typedef struct packed {
		logic              ready;
		logic [BYTE_W-1:0] held;
		logic              event_flag;
	} rx_stat_t;

endpackage

FILE: rtl/core/ubs_tx.sv
// ----------------------------------------------------------------------------
// ubs_tx
// transmit frame shifter: loads start, data and stop bits, one bit per tick
// ----------------------------------------------------------------------------
module ubs_tx (
	input  logic              clk,
	input  logic              arst_n,
	input  ubs_pkg::cmd_t     cmd,
	input  logic              event_en,
	output ubs_pkg::tx_stat_t stat
);

	logic [ubs_pkg::FRAME_LEN-1:0] frame_q, frame_n;
	logic [ubs_pkg::TX_IDX_W-1:0]  idx_q, idx_n;
	logic                          run_q, run_n;
	logic                          done_q, done_n;
	logic                          line_q, line_n;
	logic                          ev;
	logic [ubs_pkg::DATA_BITS-1:0] byte_ext;

	assign byte_ext = ubs_pkg::DATA_BITS'(cmd.tx_byte);

	always_comb begin
		frame_n = frame_q;
		idx_n   = idx_q;
		run_n   = run_q;
		done_n  = done_q;
		line_n  = line_q;
		ev      = 1'b0;
		case (cmd.op)
			ubs_pkg::OP_TX_TICK: begin
				if (run_q) begin
					if (idx_q < ubs_pkg::TX_IDX_W'(ubs_pkg::FRAME_LEN)) begin
						line_n  = frame_q[0];
						frame_n = frame_q >> 1;
						idx_n   = idx_q + 1'b1;
					end else begin
						done_n = 1'b1;
						run_n  = 1'b0;
						ev     = event_en;
					end
				end
			end
			ubs_pkg::OP_SEND: begin
				frame_n = {1'b1, byte_ext, 1'b0};
				idx_n   = '0;
				done_n  = 1'b0;
				run_n   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			idx_q   <= '0;
			run_q   <= 1'b0;
			done_q  <= 1'b1;
			line_q  <= 1'b1;
		end else if (cmd.step) begin
			frame_q <= frame_n;
			idx_q   <= idx_n;
			run_q   <= run_n;
			done_q  <= done_n;
			line_q  <= line_n;
		end
	end

	assign stat.line       = line_n;
	assign stat.done       = done_n;
	assign stat.event_flag = ev;

endmodule

FILE: rtl/core/ubs_rx.sv
// ----------------------------------------------------------------------------
// ubs_rx
// receive shifter: started by an edge event while armed, samples data bits lsb first
// ----------------------------------------------------------------------------
module ubs_rx (
	input  logic              clk,
	input  logic              arst_n,
	input  ubs_pkg::cmd_t     cmd,
	input  logic              event_en,
	output ubs_pkg::rx_stat_t stat
);

	logic [ubs_pkg::DATA_BITS-1:0] shift_q, shift_n;
	logic [ubs_pkg::RX_IDX_W-1:0]  idx_q, idx_n;
	logic                          run_q, run_n;
	logic                          armed_q, armed_n;
	logic [ubs_pkg::BYTE_W-1:0]    held_q, held_n;
	logic                          ready_q, ready_n;
	logic                          ev;

	always_comb begin
		shift_n = shift_q;
		idx_n   = idx_q;
		run_n   = run_q;
		armed_n = armed_q;
		held_n  = held_q;
		ready_n = ready_q;
		ev      = 1'b0;
		case (cmd.op)
			ubs_pkg::OP_RX_TICK: begin
				if (run_q && (idx_q < ubs_pkg::RX_IDX_W'(ubs_pkg::DATA_BITS))) begin
					shift_n = {cmd.rx_level, shift_q[ubs_pkg::DATA_BITS-1:1]};
					idx_n   = idx_q + 1'b1;
					if (idx_n == ubs_pkg::RX_IDX_W'(ubs_pkg::DATA_BITS)) begin
						run_n   = 1'b0;
						armed_n = 1'b1;
						held_n  = ubs_pkg::BYTE_W'(shift_n);
						ready_n = 1'b1;
						ev      = event_en;
					end
				end
			end
			ubs_pkg::OP_RX_EDGE: begin
				if (armed_q) begin
					idx_n   = '0;
					shift_n = '0;
					armed_n = 1'b0;
					run_n   = 1'b1;
				end
			end
			ubs_pkg::OP_READ: begin
				ready_n = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			idx_q   <= '0;
			run_q   <= 1'b0;
			armed_q <= 1'b1;
			held_q  <= '0;
			ready_q <= 1'b0;
		end else if (cmd.step) begin
			shift_q <= shift_n;
			idx_q   <= idx_n;
			run_q   <= run_n;
			armed_q <= armed_n;
			held_q  <= held_n;
			ready_q <= ready_n;
		end
	end

	assign stat.ready      = ready_n;
	assign stat.held       = held_n;
	assign stat.event_flag = ev;

endmodule

FILE: rtl/core/uart_bit_serializer.sv
// ----------------------------------------------------------------------------
// uart_bit_serializer
// event driven 8n1 uart bit engine with stream input and result channels
// ----------------------------------------------------------------------------
// Takes one event per clock, unless m_tready stalls the result register, and
// gives one result per event. An event sits in the input register, updates the
// transmit and receive state as it leaves it and lands in the result register,
// from which its result is offered on m_tvalid. The limit is the state update
// loop of the tx and rx shifters. Configuration writes are taken at any time
// with cfg_ready held high and apply to events still to be processed, so write
// them while no event is in flight.
// ----------------------------------------------------------------------------
module uart_bit_serializer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // tx_byte[7:0], rx_level[8], zero[15:9]
	input  logic [2:0]  s_tuser,   // op[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // tx_line[0], tx_done[1], rx_ready[2],
	                               // rx_byte[10:3], tx_done_event[11],
	                               // rx_done_event[12], zero[15:13]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic        cfg_data
);

	logic                           valid_s1;
	logic [ubs_pkg::OP_W-1:0]       op_s1;
	logic [ubs_pkg::BYTE_W-1:0]     byte_s1;
	logic                           level_s1;
	logic                           out_valid_q;
	logic [ubs_pkg::OUT_DATA_W-1:0] out_data_q;
	logic                           out_ready;
	logic                           adv;
	logic                           tx_ev_en_q;
	logic                           rx_ev_en_q;
	ubs_pkg::cmd_t                  cmd;
	ubs_pkg::tx_stat_t              tx_stat;
	ubs_pkg::rx_stat_t              rx_stat;

	assign out_ready = !out_valid_q || m_tready;
	assign adv       = valid_s1 && out_ready;
	assign s_tready  = !valid_s1 || out_ready;
	assign cfg_ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_ev_en_q <= 1'b0;
			rx_ev_en_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				ubs_pkg::CFG_TX_EVENT: tx_ev_en_q <= cfg_data;
				ubs_pkg::CFG_RX_EVENT: rx_ev_en_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= s_tuser;
			byte_s1  <= s_tdata[7:0];
			level_s1 <= s_tdata[8];
		end
	end

	assign cmd.step     = adv;
	assign cmd.op       = op_s1;
	assign cmd.tx_byte  = byte_s1;
	assign cmd.rx_level = level_s1;

	ubs_tx u_tx (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.event_en (tx_ev_en_q),
		.stat     (tx_stat)
	);

	ubs_rx u_rx (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.event_en (rx_ev_en_q),
		.stat     (rx_stat)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {3'b000, rx_stat.event_flag, tx_stat.event_flag, rx_stat.held,
				rx_stat.ready, tx_stat.done, tx_stat.line};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1)
		else $error("input stalled with empty input register");

	a_tx_event_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[11] |-> m_tdata[1])
		else $error("tx event without tx_done");

	a_rx_event_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[12] |-> m_tdata[2])
		else $error("rx event without rx_ready");

	a_tx_event_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		adv && tx_stat.event_flag |-> tx_ev_en_q)
		else $error("tx event while disabled");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_tvalid)
		else $error("processed item produced no result");

endmodule

FILE: tb/uart_bit_checker.sv
// ----------------------------------------------------------------------------
// uart_bit_checker
// Watches the request, result and register channels of the uart bit
// serializer. It steps a model of the tx and rx engines on every accepted
// request and queues the status that request should produce. Each accepted
// result is then compared field by field with the oldest queued status.
// ----------------------------------------------------------------------------
module uart_bit_checker
	import ubs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // tx_byte[7:0], rx_level[8], zero[15:9]
	input  logic [2:0]  s_tuser,   // op[2:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // tx_line[0], tx_done[1], rx_ready[2],
	                               // rx_byte[10:3], tx_done_event[11],
	                               // rx_done_event[12], zero[15:13]
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic        cfg_data,
	output int          errors,
	output int          pending,
	output int          checked,
	output int          frames_sent,
	output int          bytes_received
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic              rx_event;
		logic              tx_event;
		logic [BYTE_W-1:0] rx_byte;
		logic              rx_ready;
		logic              tx_done;
		logic              tx_line;
	} line_status_t;

	logic                 tx_event_en;
	logic                 rx_event_en;
	logic [FRAME_LEN-1:0] tx_frame;
	logic [TX_IDX_W-1:0]  tx_pos;
	logic                 tx_busy;
	logic                 tx_idle;
	logic                 tx_level;
	logic [BYTE_W-1:0]    rx_shift;
	logic [BYTE_W-1:0]    rx_hold;
	logic [RX_IDX_W-1:0]  rx_pos;
	logic                 rx_busy;
	logic                 rx_armed;
	logic                 rx_avail;
	line_status_t         status_due[$];

	function automatic line_status_t step_engine(input logic [OP_W-1:0] op,
		input logic [BYTE_W-1:0] tx_byte, input logic rx_level);
		line_status_t s;
		s = '0;
		case (op)
		OP_TX_TICK: begin
			if (tx_busy) begin
				if (tx_pos < FRAME_LEN) begin
					tx_level = tx_frame[tx_pos];
					tx_pos++;
				end else begin
					tx_idle = 1'b1;
					tx_busy = 1'b0;
					s.tx_event = tx_event_en;
					frames_sent++;
				end
			end
		end
		OP_RX_TICK: begin
			if (rx_busy && rx_pos < DATA_BITS) begin
				rx_shift[rx_pos] = rx_level;
				rx_pos++;
				if (rx_pos == DATA_BITS) begin
					rx_busy = 1'b0;
					rx_armed = 1'b1;
					rx_hold = rx_shift;
					rx_avail = 1'b1;
					s.rx_event = rx_event_en;
					bytes_received++;
				end
			end
		end
		OP_RX_EDGE: begin
			// an edge mid-byte is ignored since the receiver is not armed
			if (rx_armed) begin
				rx_pos = '0;
				rx_shift = '0;
				rx_armed = 1'b0;
				rx_busy = 1'b1;
			end
		end
		OP_SEND: begin
			// start bit low, data lsb first, stop bit high; line holds its level
			tx_frame = {1'b1, tx_byte, 1'b0};
			tx_pos = '0;
			tx_idle = 1'b0;
			tx_busy = 1'b1;
		end
		OP_READ: begin
			rx_avail = 1'b0;
		end
		default: begin
		end
		endcase
		s.tx_line = tx_level;
		s.tx_done = tx_idle;
		s.rx_ready = rx_avail;
		s.rx_byte = rx_hold;
		return s;
	endfunction

	function automatic void check_field(input string name, input logic [BYTE_W-1:0] want,
		input logic [BYTE_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		line_status_t got;
		line_status_t want;
		if (!arst_n) begin
			tx_event_en = 1'b0;
			rx_event_en = 1'b0;
			tx_frame = '0;
			tx_pos = '0;
			tx_busy = 1'b0;
			tx_idle = 1'b1;
			tx_level = 1'b1;
			rx_shift = '0;
			rx_hold = '0;
			rx_pos = '0;
			rx_busy = 1'b0;
			rx_armed = 1'b1;
			rx_avail = 1'b0;
			status_due.delete();
			errors = 0;
			checked = 0;
			frames_sent = 0;
			bytes_received = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_TX_EVENT)
					tx_event_en = cfg_data;
				else
					rx_event_en = cfg_data;
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(line_status_t)-1:0];
				if (status_due.size() == 0) begin
					$error("result with no request waiting: %h", m_tdata);
					errors++;
				end else begin
					want = status_due.pop_front();
					check_field("tx_line", want.tx_line, got.tx_line);
					check_field("tx_done", want.tx_done, got.tx_done);
					check_field("rx_ready", want.rx_ready, got.rx_ready);
					check_field("rx_byte", want.rx_byte, got.rx_byte);
					check_field("tx_done_event", want.tx_event, got.tx_event);
					check_field("rx_done_event", want.rx_event, got.rx_event);
					checked++;
				end
			end
			if (s_tvalid && s_tready)
				status_due.push_back(step_engine(s_tuser, s_tdata[BYTE_W-1:0], s_tdata[BYTE_W]));
		end
		pending = status_due.size();
	end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the uart bit serializer with a short directed sequence covering
// stopped ticks, restarts, edges mid-byte and unknown ops, then with random
// send/tick and edge/tick/read sequences mixed with noise, under each
// setting of the two event enables. Both stream sides stall at random; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ubs_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
	localparam int RANDOM_PER_PHASE = 125;
	localparam int STALL_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // tx_byte[7:0], rx_level[8], zero[15:9]
	logic [2:0]  s_tuser;   // op[2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // tx_line[0], tx_done[1], rx_ready[2], rx_byte[10:3],
	                        // tx_done_event[11], rx_done_event[12], zero[15:13]
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic        cfg_data;

	int          errors;
	int          pending;
	int          checked;
	int          frames_sent;
	int          bytes_received;
	int          requests_sent = 0;
	int          idle_cycles = 0;
	int unsigned tx_left = 0;
	int unsigned rx_left = 0;
	int unsigned wr_run = 0;
	int unsigned rd_run = 0;
	bit          wr_calm = 1'b0;
	bit          rd_calm = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	uart_bit_serializer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	uart_bit_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.errors         (errors),
		.pending        (pending),
		.checked        (checked),
		.frames_sent    (frames_sent),
		.bytes_received (bytes_received)
	);

	// stretches of random waits and stretches of none, each picked at random
	function automatic int unsigned draw_wait(ref int unsigned run_left, ref bit calm);
		if (run_left == 0) begin
			calm = ($urandom_range(0, 3) == 0);
			run_left = $urandom_range(10, 40);
		end
		run_left--;
		return calm ? 0 : $urandom_range(0, 12);
	endfunction

	task automatic put_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] txb,
		input logic lvl);
		int unsigned gap;
		gap = draw_wait(wr_run, wr_calm);
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser = op;
		s_tdata = {7'd0, lvl, txb};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_enables(input logic tx_en, input logic rx_en);
		drain();
		repeat (4) @(negedge clk);
		cfg_index = CFG_TX_EVENT;
		cfg_data = tx_en;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_index = CFG_RX_EVENT;
		cfg_data = rx_en;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// mostly whole frames and whole bytes, sometimes cut short, plus noise
	task automatic random_item();
		logic [OP_W-1:0] op;
		int unsigned     pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			op = OP_W'($urandom_range(0, 7));
		end else if (pick < 50) begin
			if (tx_left == 0) begin
				op = OP_SEND;
				tx_left = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : FRAME_LEN + 1;
			end else begin
				op = OP_TX_TICK;
				tx_left--;
			end
		end else if (pick < 92) begin
			if (rx_left == 0) begin
				op = OP_RX_EDGE;
				rx_left = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 7) : DATA_BITS;
			end else begin
				op = OP_RX_TICK;
				rx_left--;
			end
		end else begin
			op = OP_READ;
		end
		put_item(op, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		int unsigned stall;
		m_tready = 1'b0;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall != 0) begin
				m_tready = 1'b0;
				stall--;
			end else begin
				m_tready = 1'b1;
			end
			@(posedge clk);
			if (m_tvalid && m_tready)
				stall = draw_wait(rd_run, rd_calm);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = 1'b0;
		cfg_data = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_enables(1'b1, 1'b1);
		put_item(OP_UNUSED, 8'hFF, 1'b1);
		put_item(OP_TX_TICK, 8'h00, 1'b0);
		put_item(OP_RX_TICK, 8'h00, 1'b1);
		put_item(OP_READ, 8'h00, 1'b0);
		put_item(OP_SEND, 8'hFF, 1'b0);
		put_item(OP_TX_TICK, 8'h00, 1'b0);
		// restart mid-frame, line stays low until the next tick
		put_item(OP_SEND, 8'h00, 1'b0);
		repeat (FRAME_LEN + 1)
			put_item(OP_TX_TICK, 8'h00, 1'b0);
		put_item(OP_RX_EDGE, 8'h00, 1'b0);
		put_item(OP_RX_EDGE, 8'h00, 1'b0);
		repeat (DATA_BITS)
			put_item(OP_RX_TICK, 8'h00, 1'b1);
		put_item(OP_READ, 8'h00, 1'b0);

		for (int ph = 0; ph < 4; ph++) begin
			write_enables(ph[0], ph[1]);
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				if (i == RANDOM_PER_PHASE / 2)
					drain();
				random_item();
			end
		end

		drain();
		repeat (8) @(negedge clk);
		$display("%0d requests, %0d results checked: %0d frames sent, %0d bytes received,",
			requests_sent, checked, frames_sent, bytes_received);
		$display("under all four event-enable settings with random stalls on both sides");
		if (errors == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
